[rtl/julia_escape_time_assert.svh]
// ----------------------------------------------------------------------------
// julia_escape_time_assert.svh
// Assertion macros shared by the julia escape-time RTL
// ----------------------------------------------------------------------------
`ifndef JULIA_ESCAPE_TIME_ASSERT_SVH
`define JULIA_ESCAPE_TIME_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define JET_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define JET_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/jet_pkg.sv]
// ----------------------------------------------------------------------------
// jet_pkg
// Types and fixed constants of the julia escape-time block
// ----------------------------------------------------------------------------
`default_nettype none

package jet_pkg;

  localparam int PIX_W     = 10;  // pixel coordinate width
  localparam int IDX_W     = 6;   // escape index width
  localparam int Z_W       = 32;  // Q4.28 value width
  localparam int FRAC_W    = 28;  // fraction bits
  localparam int MAP_SHIFT = 30;  // 4 * 2^28 scale of the start mapping
  localparam int QUO_W     = MAP_SHIFT;          // width of 2^30 / span
  localparam int PQ_W      = PIX_W + QUO_W;      // pixel times quotient
  localparam int SAT_IN_W  = PQ_W + 2;           // pre-saturation width
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = Z_W;

  localparam logic [CFG_IDX_W-1:0] CFG_C_REAL = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_C_IMAG = 1'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic signed [Z_W-1:0] zval_t;

  typedef struct packed {
    pix_t pixel_x;
    pix_t pixel_y;
  } in_beat_t;

  typedef struct packed {
    pix_t             out_x;
    pix_t             out_y;
    logic [IDX_W-1:0] escape_index;
    logic             escaped;
  } out_beat_t;

  // clamp a wide signed value to signed Q4.28
  function automatic zval_t sat_z(input logic signed [SAT_IN_W-1:0] v);
    zval_t r;
    if ((v[SAT_IN_W-1:Z_W-1] == '0) || (v[SAT_IN_W-1:Z_W-1] == '1)) begin
      r = v[Z_W-1:0];
    end else if (v[SAT_IN_W-1]) begin
      r = {1'b1, {(Z_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(Z_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/jet_stream_if.sv]
// ----------------------------------------------------------------------------
// jet_stream_if
// Valid/ready stream channel carrying one payload per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface jet_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

`default_nettype wire

[rtl/julia_escape_time.sv]
// ----------------------------------------------------------------------------
// julia_escape_time
// Julia set escape-time engine, one pixel per input beat, Q4.28 arithmetic
// ----------------------------------------------------------------------------
// Each input beat carries a pixel (pixel_x, pixel_y). The pixel is mapped to a
// start value z (x over -2..+2, y over +2..-2), then z = z*z + c is repeated
// with c from the two configuration registers until |z|^2 exceeds 4 or
// MAX_ITER-1 updates are done; the result beat echoes the pixel with the
// escape index and an escaped flag. One pixel is in flight at a time. The
// start mapping runs through S_MAP, S_DIV and S_INIT (a multiply by the
// integer part of the scale, a reciprocal multiply for the floored remainder
// part, a saturation step), then every iteration runs S_MUL and S_UPD on the
// three shared 32x32 multipliers (square, then update and escape test). A
// finished pixel holds in S_UPD until the output register is free, then the
// block returns to idle. The result sits in an output register, so the next
// pixel is accepted while the previous result waits.
// ----------------------------------------------------------------------------
`default_nettype none
`include "julia_escape_time_assert.svh"

module julia_escape_time #(
  parameter int WIDTH    = 1024,
  parameter int HEIGHT   = 1024,
  parameter int MAX_ITER = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [jet_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [jet_pkg::CFG_W-1:0]     cfg_data_i,
  jet_stream_if.sink                         in_ch,
  jet_stream_if.source                       out_ch
);

  import jet_pkg::*;

  localparam int ITW  = (MAX_ITER > 2) ? $clog2(MAX_ITER) : 1;
  localparam int SPAN_W = ($clog2(WIDTH) > $clog2(HEIGHT)) ? $clog2(WIDTH) : $clog2(HEIGHT);
  localparam int DW   = SPAN_W + PIX_W + 1;

  // offset = p * (2^30 / span) + (p * (2^30 % span)) / span
  localparam logic [QUO_W-1:0] QX = QUO_W'((64'd1 << MAP_SHIFT) / WIDTH);
  localparam logic [QUO_W-1:0] QY = QUO_W'((64'd1 << MAP_SHIFT) / HEIGHT);
  localparam logic [DW-1:0]    RX = DW'((64'd1 << MAP_SHIFT) % WIDTH);
  localparam logic [DW-1:0]    RY = DW'((64'd1 << MAP_SHIFT) % HEIGHT);

  // remainder part p * R < 2^NUM_W, divided by a rounded-up reciprocal
  localparam int NUM_W = SPAN_W + PIX_W;
  localparam int SX    = NUM_W + $clog2(WIDTH);
  localparam int SY    = NUM_W + $clog2(HEIGHT);
  localparam int MW    = NUM_W + 2;
  localparam int PRW   = DW + MW;
  localparam logic [MW-1:0] MX = MW'(((64'd1 << SX) + 64'(WIDTH) - 64'd1) / 64'(WIDTH));
  localparam logic [MW-1:0] MY = MW'(((64'd1 << SY) + 64'(HEIGHT) - 64'd1) / 64'(HEIGHT));

  localparam logic signed [SAT_IN_W-1:0] TWO = SAT_IN_W'(64'd1 << (FRAC_W + 1));
  localparam logic [2*Z_W:0] ESC_LIMIT = (2*Z_W+1)'(1) << (FRAC_W * 2 + 2);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAP  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_UPD  = 3'd5;

  logic [2:0]        state_q;
  logic [ITW-1:0]    it_q;
  logic              out_valid_q;
  zval_t             c_real_q, c_imag_q;

  pix_t              px_q, py_q;
  logic [PQ_W-1:0]   pq_x_q, pq_y_q;
  logic [DW-1:0]     rem_x_q, rem_y_q;
  pix_t              quo_x_q, quo_y_q;
  zval_t             z_re_q, z_im_q;
  logic signed [2*Z_W-1:0] prod_rr_q, prod_ii_q, prod_ri_q;
  out_beat_t         out_q;

  logic                      in_fire, esc_hit, at_last, finish, out_free, emit, sq_neg;
  logic [PRW-1:0]            rq_x, rq_y;
  logic [PQ_W:0]             off_x, off_y;
  logic signed [SAT_IN_W-1:0] start_re, start_im, next_re, next_im;
  logic signed [2*Z_W:0]     diff, diff_sh;
  logic signed [2*Z_W-1:0]   ri_sh;
  logic [2*Z_W:0]            mag;
  logic [ITW-1:0]            idx_full;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_q == S_IDLE);
  assign out_ch.valid = out_valid_q;
  assign out_ch.payload = out_q;

  always_comb begin
    rq_x = PRW'(rem_x_q) * PRW'(MX);
    rq_y = PRW'(rem_y_q) * PRW'(MY);

    off_x = (PQ_W+1)'(pq_x_q) + (PQ_W+1)'(quo_x_q);
    off_y = (PQ_W+1)'(pq_y_q) + (PQ_W+1)'(quo_y_q);
    start_re = $signed({1'b0, off_x}) - TWO;
    start_im = TWO - $signed({1'b0, off_y});

    // floor shifts of the squared terms, then add c
    diff    = $signed({prod_rr_q[2*Z_W-1], prod_rr_q})
            - $signed({prod_ii_q[2*Z_W-1], prod_ii_q});
    diff_sh = diff >>> FRAC_W;
    ri_sh   = prod_ri_q >>> (FRAC_W - 1);
    next_re = SAT_IN_W'(diff_sh) + SAT_IN_W'(c_real_q);
    next_im = SAT_IN_W'(ri_sh) + SAT_IN_W'(c_imag_q);

    // squares of the latest z double as the escape test of the previous update
    mag      = {1'b0, prod_rr_q} + {1'b0, prod_ii_q};
    esc_hit  = (it_q != '0) && (mag > ESC_LIMIT);
    at_last  = (it_q == ITW'(MAX_ITER - 1));
    finish   = esc_hit || at_last;
    out_free = !out_valid_q || out_ch.ready;
    emit     = (state_q == S_UPD) && finish && out_free;
    idx_full = it_q - ITW'(1);
    sq_neg   = prod_rr_q[2*Z_W-1] || prod_ii_q[2*Z_W-1];
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      it_q        <= '0;
      out_valid_q <= 1'b0;
      c_real_q    <= '0;
      c_imag_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_C_REAL: c_real_q <= cfg_data_i;
          CFG_C_IMAG: c_imag_q <= cfg_data_i;
        endcase
      end

      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_MAP;
          end
        end
        S_MAP: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          state_q <= S_INIT;
        end
        S_INIT: begin
          it_q    <= '0;
          state_q <= S_MUL;
        end
        S_MUL: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          if (finish) begin
            // hold here until the output register is free
            if (out_free) begin
              state_q <= S_IDLE;
            end
          end else begin
            it_q    <= it_q + ITW'(1);
            state_q <= S_MUL;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          px_q <= in_ch.payload.pixel_x;
          py_q <= in_ch.payload.pixel_y;
        end
      end
      S_MAP: begin
        pq_x_q  <= PQ_W'(px_q) * PQ_W'(QX);
        pq_y_q  <= PQ_W'(py_q) * PQ_W'(QY);
        rem_x_q <= DW'(px_q) * RX;
        rem_y_q <= DW'(py_q) * RY;
      end
      S_DIV: begin
        quo_x_q <= rq_x[SX +: PIX_W];
        quo_y_q <= rq_y[SY +: PIX_W];
      end
      S_INIT: begin
        z_re_q <= sat_z(start_re);
        z_im_q <= sat_z(start_im);
      end
      S_MUL: begin
        prod_rr_q <= z_re_q * z_re_q;
        prod_ii_q <= z_im_q * z_im_q;
        prod_ri_q <= z_re_q * z_im_q;
      end
      S_UPD: begin
        if (finish) begin
          if (out_free) begin
            out_q.out_x        <= px_q;
            out_q.out_y        <= py_q;
            out_q.escaped      <= esc_hit;
            out_q.escape_index <= esc_hit ? IDX_W'(idx_full) : '0;
          end
        end else begin
          z_re_q <= sat_z(next_re);
          z_im_q <= sat_z(next_im);
        end
      end
      default: begin
      end
    endcase
  end

  `JET_ASSERT_NXT(a_accept_starts_map, in_fire, state_q == S_MAP, "accept without mapping")
  `JET_ASSERT_IMP(a_result_src, $rose(out_valid_q), $past(state_q) == S_UPD, "stray result")
  `JET_ASSERT_IMP(a_squares_nonneg, state_q == S_UPD, !sq_neg, "negative square")
  `JET_ASSERT_NXT(a_div_exits_to_init, state_q == S_DIV, state_q == S_INIT, "divider left early")

endmodule

`default_nettype wire
